FILE: src/serial_rx_tx_ring_buffers_macros.svh
// Assertion macros for the serial ring buffer block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SERIAL_RX_TX_RING_BUFFERS_MACROS_SVH
`define SERIAL_RX_TX_RING_BUFFERS_MACROS_SVH
`ifndef ASSERT_OFF
`define SRRB_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define SRRB_ASSERT_NEVER(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SRRB_ASSERT_IMP(lbl, ante, cons, msg)
`define SRRB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/srrb_pkg.sv
// Shared types and constants of the serial ring buffer block.
// No dependencies; used by every other file but the macros header.
package srrb_pkg;

	localparam int RX_DEPTH_DEF = 128;
	localparam int TX_DEPTH_DEF = 32;
	localparam int Q_DEPTH      = 2;
	localparam int RX_LEVEL_W   = 8;
	localparam int TX_LEVEL_W   = 6;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [1:0] {
		CMD_RX_BYTE  = 2'd0,
		CMD_HOST_WR  = 2'd1,
		CMD_HOST_RD  = 2'd2,
		CMD_LINE_RDY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DROP  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// memory operation the back end carries out for one word
	typedef enum logic [2:0] {
		OP_NONE,
		OP_RX_PUSH,
		OP_RX_POP,
		OP_TX_PUSH,
		OP_TX_PUSH_NL,
		OP_TX_POP
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [7:0]            data;
		status_t               status;
		logic [RX_LEVEL_W-1:0] rx_level;
		logic [TX_LEVEL_W-1:0] tx_level;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_RX,
		SEL_TX
	} sel_t;

endpackage

FILE: src/srrb_if.sv
// Valid/ready channel interfaces for the serial ring buffer block.
// Depends on srrb_pkg for the level widths.
interface srrb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_in;

	modport source (output valid, output cmd, output data_in, input ready);
	modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface srrb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      status;
	logic [7:0]                      data_out;
	logic [srrb_pkg::RX_LEVEL_W-1:0] rx_level;
	logic [srrb_pkg::TX_LEVEL_W-1:0] tx_level;

	modport source (output valid, output status, output data_out, output rx_level,
		output tx_level, input ready);
	modport sink   (input valid, input status, input data_out, input rx_level,
		input tx_level, output ready);
endinterface

FILE: src/srrb_front.sv
// Front end: accepts request words, tracks ring fill levels, classifies ops.
// Depends on srrb_pkg and srrb_if.
module srrb_front #(
	parameter int RX_DEPTH = srrb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = srrb_pkg::TX_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	srrb_req_if.sink          req,
	input  srrb_pkg::q_stat_t q_stat,
	output logic              push,
	output srrb_pkg::entry_t  entry
);

	localparam int RCW = $clog2(RX_DEPTH + 1);
	localparam int TCW = $clog2(TX_DEPTH + 1);

	logic [RCW-1:0] rx_cnt_q, rx_cnt_nxt;
	logic [TCW-1:0] tx_cnt_q, tx_cnt_nxt;
	logic [TCW:0]   tx_sum;
	logic [1:0]     tx_need;
	logic           is_lf;
	srrb_pkg::op_t     op;
	srrb_pkg::status_t status;

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full;

	assign is_lf   = (req.data_in == srrb_pkg::CH_LF);
	assign tx_need = is_lf ? 2'd2 : 2'd1;
	assign tx_sum  = {1'b0, tx_cnt_q} + (TCW+1)'(tx_need);

	always_comb begin
		op         = srrb_pkg::OP_NONE;
		status     = srrb_pkg::ST_OK;
		rx_cnt_nxt = rx_cnt_q;
		tx_cnt_nxt = tx_cnt_q;
		unique case (srrb_pkg::cmd_t'(req.cmd))
			srrb_pkg::CMD_RX_BYTE: begin
				if (rx_cnt_q == RCW'(RX_DEPTH)) begin
					status = srrb_pkg::ST_DROP;
				end else begin
					op         = srrb_pkg::OP_RX_PUSH;
					rx_cnt_nxt = rx_cnt_q + RCW'(1);
				end
			end
			srrb_pkg::CMD_HOST_WR: begin
				if (tx_sum > (TCW+1)'(TX_DEPTH)) begin
					status = srrb_pkg::ST_FULL;
				end else begin
					op         = is_lf ? srrb_pkg::OP_TX_PUSH_NL : srrb_pkg::OP_TX_PUSH;
					tx_cnt_nxt = tx_sum[TCW-1:0];
				end
			end
			srrb_pkg::CMD_HOST_RD: begin
				if (rx_cnt_q == '0) begin
					status = srrb_pkg::ST_EMPTY;
				end else begin
					op         = srrb_pkg::OP_RX_POP;
					rx_cnt_nxt = rx_cnt_q - RCW'(1);
				end
			end
			srrb_pkg::CMD_LINE_RDY: begin
				if (tx_cnt_q == '0) begin
					status = srrb_pkg::ST_EMPTY;
				end else begin
					op         = srrb_pkg::OP_TX_POP;
					tx_cnt_nxt = tx_cnt_q - TCW'(1);
				end
			end
			default: begin
				status = srrb_pkg::ST_EMPTY;
			end
		endcase
	end

	always_comb begin
		entry.op       = op;
		entry.data     = req.data_in;
		entry.status   = status;
		entry.rx_level = srrb_pkg::RX_LEVEL_W'(rx_cnt_nxt);
		entry.tx_level = srrb_pkg::TX_LEVEL_W'(tx_cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt_q <= '0;
			tx_cnt_q <= '0;
		end else if (push) begin
			rx_cnt_q <= rx_cnt_nxt;
			tx_cnt_q <= tx_cnt_nxt;
		end
	end

endmodule

FILE: src/srrb_queue.sv
// Short FIFO of classified ops between front and back end.
// Depends on srrb_pkg.
module srrb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srrb_pkg::entry_t  push_entry,
	input  logic              pop,
	output srrb_pkg::entry_t  head,
	output srrb_pkg::q_stat_t q_stat
);

	localparam int QD  = srrb_pkg::Q_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	srrb_pkg::entry_t slot_q [QD];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QCW-1:0]   cnt_q;

	assign head         = slot_q[rd_q];
	assign q_stat.full  = (cnt_q == QCW'(QD));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QAW'(QD - 1)) ? '0 : wr_q + QAW'(1);
			if (pop)  rd_q <= (rd_q == QAW'(QD - 1)) ? '0 : rd_q + QAW'(1);
			if (push && !pop)      cnt_q <= cnt_q + QCW'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCW'(1);
		end
	end

endmodule

FILE: src/srrb_back.sv
// Back end: ring memories, slot indices and the output register.
// Depends on srrb_pkg and srrb_if.
module srrb_back #(
	parameter int RX_DEPTH = srrb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = srrb_pkg::TX_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srrb_pkg::entry_t  head,
	input  srrb_pkg::q_stat_t q_stat,
	output logic              pop,
	srrb_rsp_if.source        rsp
);

	localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TAW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

	logic [7:0]     rx_mem [RX_DEPTH];
	logic [7:0]     tx_mem [TX_DEPTH];
	logic [RAW-1:0] rx_wi_q, rx_ri_q;
	logic [TAW-1:0] tx_wi_q, tx_ri_q;
	logic [7:0]     rx_rd_q, tx_rd_q, tx_wdata;
	logic           nl_q;
	logic           rx_we, rx_re, tx_we, tx_re;

	logic                            out_v_q;
	srrb_pkg::status_t               status_q;
	srrb_pkg::sel_t                  sel_q;
	logic [srrb_pkg::RX_LEVEL_W-1:0] rxl_q;
	logic [srrb_pkg::TX_LEVEL_W-1:0] txl_q;

	// nl_q: the LF half of a newline still has to be written
	assign pop   = !q_stat.empty && !nl_q && (!out_v_q || rsp.ready);
	assign rx_we = pop && (head.op == srrb_pkg::OP_RX_PUSH);
	assign rx_re = pop && (head.op == srrb_pkg::OP_RX_POP);
	assign tx_re = pop && (head.op == srrb_pkg::OP_TX_POP);
	assign tx_we = nl_q || (pop && (head.op == srrb_pkg::OP_TX_PUSH ||
		head.op == srrb_pkg::OP_TX_PUSH_NL));

	always_comb begin
		if (nl_q)                                tx_wdata = srrb_pkg::CH_LF;
		else if (head.op == srrb_pkg::OP_TX_PUSH_NL) tx_wdata = srrb_pkg::CH_CR;
		else                                     tx_wdata = head.data;
	end

	always_ff @(posedge clk) begin
		if (rx_we) rx_mem[rx_wi_q] <= head.data;
		if (rx_re) rx_rd_q <= rx_mem[rx_ri_q];
	end

	always_ff @(posedge clk) begin
		if (tx_we) tx_mem[tx_wi_q] <= tx_wdata;
		if (tx_re) tx_rd_q <= tx_mem[tx_ri_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wi_q <= '0;
			rx_ri_q <= '0;
			tx_wi_q <= '0;
			tx_ri_q <= '0;
			nl_q    <= 1'b0;
		end else begin
			if (rx_we) rx_wi_q <= (rx_wi_q == RAW'(RX_DEPTH - 1)) ? '0 : rx_wi_q + RAW'(1);
			if (rx_re) rx_ri_q <= (rx_ri_q == RAW'(RX_DEPTH - 1)) ? '0 : rx_ri_q + RAW'(1);
			if (tx_we) tx_wi_q <= (tx_wi_q == TAW'(TX_DEPTH - 1)) ? '0 : tx_wi_q + TAW'(1);
			if (tx_re) tx_ri_q <= (tx_ri_q == TAW'(TX_DEPTH - 1)) ? '0 : tx_ri_q + TAW'(1);
			nl_q <= pop && (head.op == srrb_pkg::OP_TX_PUSH_NL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= head.status;
			rxl_q    <= head.rx_level;
			txl_q    <= head.tx_level;
			if (head.op == srrb_pkg::OP_RX_POP)      sel_q <= srrb_pkg::SEL_RX;
			else if (head.op == srrb_pkg::OP_TX_POP) sel_q <= srrb_pkg::SEL_TX;
			else                                     sel_q <= srrb_pkg::SEL_ZERO;
		end
	end

	always_comb begin
		case (sel_q)
			srrb_pkg::SEL_RX: rsp.data_out = rx_rd_q;
			srrb_pkg::SEL_TX: rsp.data_out = tx_rd_q;
			default:          rsp.data_out = 8'd0;
		endcase
	end

	assign rsp.valid    = out_v_q;
	assign rsp.status   = status_q;
	assign rsp.rx_level = rxl_q;
	assign rsp.tx_level = txl_q;

endmodule

FILE: src/serial_rx_tx_ring_buffers.sv
// Top level of the serial port receive/transmit ring buffers.
// Depends on srrb_pkg, srrb_if, srrb_front, srrb_queue, srrb_back and the macros header.
//
// Each request word is one event: line byte received, host write, host read,
// or line ready; each gives exactly one response word with a status, the
// byte read or sent (zero otherwise) and both ring levels after the event.
// A full receive ring drops the byte; a host write needing more room than is
// free (two slots for a newline, which is stored as CR then LF) reports full
// and stores nothing; an empty ring reports empty.
// Rate: one word per cycle while rsp.ready holds; a newline write holds the back end
// while CR and then LF are written, since the transmit memory takes one write per cycle.
// Path from request accept to response valid: the front end registers the op into a
// two-entry queue, the back end pops it once the output register is free and no LF
// is pending, does the memory access (two writes for a newline) and loads the output
// register. The front end keeps accepting while a response waits, until the queue fills.
// Ring contents are not cleared at reset; only the levels and indices are.
`include "serial_rx_tx_ring_buffers_macros.svh"

module serial_rx_tx_ring_buffers #(
	parameter int RX_DEPTH = srrb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = srrb_pkg::TX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srrb_req_if.sink   req,
	srrb_rsp_if.source rsp
);

	srrb_pkg::entry_t  entry;
	srrb_pkg::entry_t  head;
	srrb_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	// front end: level bookkeeping and status decisions
	srrb_front #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_stat (q_stat),
		.push   (push),
		.entry  (entry)
	);

	// decoupling queue
	srrb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// back end: memories and response register
	srrb_back #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.rsp    (rsp)
	);

	`SRRB_ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty, "queue full and empty")
	`SRRB_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
	`SRRB_ASSERT_IMP(a_push_room, push, !q_stat.full, "push into full queue")
	`SRRB_ASSERT_IMP(a_rx_level, push, entry.rx_level <= 8'(RX_DEPTH), "rx level past depth")

endmodule
